/* sv/otv_pkg.sv */
// Shared types, constants and register codes for the orbital thrust block.
package otv_pkg;

   localparam int DIR_FRAC_BITS_DEF = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] REG_THROTTLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_THRUST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ISP        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CUSTOM     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_MASS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_START_MASS = 3'd6;

   localparam logic [2:0] MODE_PRO      = 3'd0;
   localparam logic [2:0] MODE_RETRO    = 3'd1;
   localparam logic [2:0] MODE_RAD_IN   = 3'd2;
   localparam logic [2:0] MODE_RAD_OUT  = 3'd3;
   localparam logic [2:0] MODE_NORMAL   = 3'd4;
   localparam logic [2:0] MODE_ANTI     = 3'd5;

   localparam logic [16:0] FULL_THROTTLE = 17'd65536;
   localparam logic [19:0] G0_SCALED     = 20'd980665;

   typedef enum logic {
      KIND_STEP    = 1'b0,
      KIND_RESTORE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0]        step_us;
   } item_type;

   typedef struct packed {
      logic [16:0] throttle;
      logic [23:0] max_thrust;
      logic [15:0] specific_impulse;
      logic [2:0]  thrust_mode;
      logic [47:0] custom_direction;
      logic [39:0] dry_mass;
      logic [39:0] start_mass;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      throttle:         17'd0,
      max_thrust:       24'd0,
      specific_impulse: 16'd1,
      thrust_mode:      3'd0,
      custom_direction: 48'd0,
      dry_mass:         40'd0,
      start_mass:       40'd0
   };

endpackage

/* sv/otv_if.sv */
// Channel interfaces: step items in, results out, register writes.
interface otv_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic [31:0]        step_us;
   modport source (output valid, func, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, step_us,
                   input ready);
   modport sink (input valid, func, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, step_us,
                 output ready);
endinterface

interface otv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [32:0] thrust_x;
   logic signed [32:0] thrust_y;
   logic signed [32:0] thrust_z;
   logic [39:0]        burned;
   logic [39:0]        mass_now;
   logic               out_of_fuel;
   modport source (output valid, thrust_x, thrust_y, thrust_z, burned, mass_now, out_of_fuel,
                   input ready);
   modport sink (input valid, thrust_x, thrust_y, thrust_z, burned, mass_now, out_of_fuel,
                 output ready);
endinterface

interface otv_csr_if;
   logic                               valid;
   logic                               ready;
   logic [otv_pkg::CSR_IDX_W-1:0]      index;
   logic [otv_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/orbital_thrust_vector_and_fuel_burn.sv */
// Top level: orbital-frame thrust vector and fuel burn engine.
//
// Usage:
//   req_chan carries one step item (func, position, velocity, step_us); func
//   high reloads mass from max(start_mass, dry_mass) and clears the throttle.
//   rsp_chan returns one result per item, in order: thrust vector (Q.8
//   newtons), grams burned, mass after the item and an out-of-fuel flag.
//   csr_chan writes register index/data; ready is always high. Write only
//   while no item is in flight.
//   Sequencing: a restore or coasting item (throttle zero or no fuel) skips
//   straight to the result. A burning item runs two or three vector
//   normalizations, each a 32-step square root and three
//   (DIR_FRAC_BITS+1)-step divides, then a 64-step divide for the burn, with
//   all products formed on one shared multiplier. One item is worked at a
//   time; a two-entry queue keeps accepting items meanwhile until it is full.
//   Reset clears config registers (specific impulse 1) and craft mass to 0.
//   When rsp_chan stalls the finished result holds in its output register;
//   the next item is computed and then waits until that register frees up.
module orbital_thrust_vector_and_fuel_burn #(
   parameter int DIR_FRAC_BITS = otv_pkg::DIR_FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   otv_req_if.sink   req_chan,
   otv_rsp_if.source rsp_chan,
   otv_csr_if.sink   csr_chan
);

   otv_pkg::cfg_type  cfg;
   otv_pkg::item_type item;
   logic              item_valid;
   logic              item_pop;
   logic              thr_clear;

   otv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .thr_clear (thr_clear),
      .cfg       (cfg)
   );

   otv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   otv_back #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .thr_clear  (thr_clear),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* sv/otv_csr.sv */
// Configuration register file with throttle clear on restore.
module otv_csr (
   input  logic             clock,
   input  logic             reset,
   otv_csr_if.sink          csr_chan,
   input  logic             thr_clear,
   output otv_pkg::cfg_type cfg
);

   otv_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (thr_clear) begin
         cfg_in.throttle = 17'd0;
      end
      if (csr_chan.valid) begin
         case (csr_chan.index)
            otv_pkg::REG_THROTTLE:   cfg_in.throttle = csr_chan.data[16:0];
            otv_pkg::REG_MAX_THRUST: cfg_in.max_thrust = csr_chan.data[23:0];
            otv_pkg::REG_ISP:        cfg_in.specific_impulse = csr_chan.data[15:0];
            otv_pkg::REG_MODE:       cfg_in.thrust_mode = csr_chan.data[2:0];
            otv_pkg::REG_CUSTOM:     cfg_in.custom_direction = csr_chan.data[47:0];
            otv_pkg::REG_DRY_MASS:   cfg_in.dry_mass = csr_chan.data[39:0];
            otv_pkg::REG_START_MASS: cfg_in.start_mass = csr_chan.data[39:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= otv_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/otv_front.sv */
// Front end: accept and classify items into a two-entry queue.
module otv_front (
   input  logic              clock,
   input  logic              reset,
   otv_req_if.sink           req_chan,
   output otv_pkg::item_type item,
   output logic              item_valid,
   input  logic              item_pop
);

   otv_pkg::item_type slot_ff [2];
   otv_pkg::item_type entry;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   logic       pop;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push = req_chan.valid && req_chan.ready;
   assign item_valid = (count_ff != 2'd0);
   assign pop = item_pop && item_valid;
   assign item = slot_ff[rd_ptr_ff];

   always_comb begin
      entry.kind = req_chan.func ? otv_pkg::KIND_RESTORE : otv_pkg::KIND_STEP;
      entry.pos_x = req_chan.pos_x;
      entry.pos_y = req_chan.pos_y;
      entry.pos_z = req_chan.pos_z;
      entry.vel_x = req_chan.vel_x;
      entry.vel_y = req_chan.vel_y;
      entry.vel_z = req_chan.vel_z;
      entry.step_us = req_chan.step_us;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

/* sv/otv_back.sv */
// Back end: sequenced frame build, thrust vector, burn division and mass update.
module otv_back #(
   parameter int DIR_FRAC_BITS = otv_pkg::DIR_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  otv_pkg::cfg_type  cfg,
   input  otv_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_pop,
   output logic              thr_clear,
   otv_rsp_if.source         rsp_chan
);

   localparam int F = DIR_FRAC_BITS;
   localparam int DW = F + 2;
   localparam logic [5:0] SQRT_LAST = 6'd31;
   localparam logic [5:0] DIV_LAST = 6'd63;
   localparam logic [5:0] NDIV_LAST = 6'(F);
   localparam logic [63:0] RND64 = (64'd1 << F) - 64'd1;
   localparam logic [67:0] RND68 = (68'd1 << F) - 68'd1;
   localparam logic signed [DW-1:0] ONE_DIR = DW'(64'd1 << F);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_PWR   = 14'b00000000000010,
      ST_ISP   = 14'b00000000000100,
      ST_NUM   = 14'b00000000001000,
      ST_NSQ   = 14'b00000000010000,
      ST_NSQRT = 14'b00000000100000,
      ST_NDLD  = 14'b00000001000000,
      ST_NDIV  = 14'b00000010000000,
      ST_CRSA  = 14'b00000100000000,
      ST_CRSB  = 14'b00001000000000,
      ST_CRSD  = 14'b00010000000000,
      ST_THR   = 14'b00100000000000,
      ST_DIV   = 14'b01000000000000,
      ST_FIN   = 14'b10000000000000
   } st_type;

   st_type st_ff, st_in;
   otv_pkg::item_type item_ff, item_in;
   logic act_ff, act_in, rst_ff, rst_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [5:0] it_ff, it_in;
   logic [1:0] nsel_ff, nsel_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [63:0] proda_ff, proda_in;
   logic [39:0] power_ff, power_in;
   logic [35:0] md_ff, md_in;
   logic [79:0] num_ff, num_in;
   logic signed [32:0] vec_ff [3];
   logic signed [32:0] vec_in [3];
   logic [63:0] sum_ff, sum_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [33:0] drem_ff, drem_in;
   logic [F:0] q_ff, q_in;
   logic signed [DW-1:0] radial_ff [3];
   logic signed [DW-1:0] radial_in [3];
   logic signed [DW-1:0] pro_ff [3];
   logic signed [DW-1:0] pro_in [3];
   logic signed [DW-1:0] normal_ff [3];
   logic signed [DW-1:0] normal_in [3];
   logic signed [32:0] thrust_ff [3];
   logic signed [32:0] thrust_in [3];
   logic [63:0] dq_ff, dq_in;
   logic [36:0] dr_ff, dr_in;
   logic [39:0] mass_ff, mass_in;
   logic rvalid_ff, rvalid_in;
   logic signed [32:0] rthr_ff [3];
   logic signed [32:0] rthr_in [3];
   logic [39:0] rburn_ff, rburn_in, rmass_ff, rmass_in;
   logic rfuel_ff, rfuel_in;

   logic [31:0] mag [3];
   logic signed [DW-1:0] dir [3];
   logic signed [47:0] cust [3];
   logic signed [47:0] custadj [3];
   logic [16:0] thr_sat;
   logic [15:0] isp_eff;
   logic [38:0] step100;
   logic signed [33:0] mul_a, mul_b;
   logic [1:0] ci;
   logic [1:0] ti;
   logic [35:0] rem2;
   logic sq_ge;
   logic nd_ge;
   logic [33:0] nd_sub;
   logic [F:0] qn;
   logic signed [DW-1:0] uq, unit;
   logic signed [63:0] cdiff, cadj, ctr;
   logic signed [67:0] tadj, ttr;
   logic [36:0] dv_r;
   logic dv_ge;
   logic [39:0] fuel, burn, mass_new, restore_mass;
   logic [79:0] part;
   logic load;

   assign ci = cnt_ff[1:0];
   assign ti = cnt_ff[1:0] - 2'd1;

   always_comb begin
      thr_sat = (cfg.throttle > otv_pkg::FULL_THROTTLE) ? otv_pkg::FULL_THROTTLE : cfg.throttle;
      isp_eff = (cfg.specific_impulse == 16'd0) ? 16'd1 : cfg.specific_impulse;
      step100 = ({7'd0, item_ff.step_us} << 6) + ({7'd0, item_ff.step_us} << 5)
              + ({7'd0, item_ff.step_us} << 2);
      for (int i = 0; i < 3; i++) begin
         mag[i] = vec_ff[i][32] ? 32'(-vec_ff[i]) : vec_ff[i][31:0];
         cust[i] = 48'($signed(cfg.custom_direction[16*i +: 16])) <<< F;
         custadj[i] = (cust[i] + (cust[i][47] ? 48'sd32767 : 48'sd0)) >>> 15;
         case (cfg.thrust_mode)
            otv_pkg::MODE_PRO:     dir[i] = pro_ff[i];
            otv_pkg::MODE_RETRO:   dir[i] = -pro_ff[i];
            otv_pkg::MODE_RAD_IN:  dir[i] = -radial_ff[i];
            otv_pkg::MODE_RAD_OUT: dir[i] = radial_ff[i];
            otv_pkg::MODE_NORMAL:  dir[i] = normal_ff[i];
            otv_pkg::MODE_ANTI:    dir[i] = -normal_ff[i];
            default:               dir[i] = DW'(custadj[i]);
         endcase
      end
   end

   // shared multiplier, operands picked by sequencer step
   always_comb begin
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      case (st_ff)
         ST_PWR: begin
            mul_a = $signed({17'd0, thr_sat});
            mul_b = $signed({10'd0, cfg.max_thrust});
         end
         ST_ISP: begin
            mul_a = $signed({18'd0, isp_eff});
            mul_b = $signed({14'd0, otv_pkg::G0_SCALED});
         end
         ST_NUM: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = $signed({13'd0, power_ff[20:0]});
                  mul_b = $signed({14'd0, step100[19:0]});
               end
               3'd1: begin
                  mul_a = $signed({13'd0, power_ff[20:0]});
                  mul_b = $signed({15'd0, step100[38:20]});
               end
               3'd2: begin
                  mul_a = $signed({15'd0, power_ff[39:21]});
                  mul_b = $signed({14'd0, step100[19:0]});
               end
               3'd3: begin
                  mul_a = $signed({15'd0, power_ff[39:21]});
                  mul_b = $signed({15'd0, step100[38:20]});
               end
               default: ;
            endcase
         end
         ST_NSQ: begin
            if (cnt_ff < 3'd3) begin
               mul_a = $signed({2'd0, mag[ci]});
               mul_b = $signed({2'd0, mag[ci]});
            end
         end
         ST_CRSA: begin
            case (ci)
               2'd0: begin mul_a = 34'(radial_ff[1]); mul_b = 34'(pro_ff[2]); end
               2'd1: begin mul_a = 34'(radial_ff[2]); mul_b = 34'(pro_ff[0]); end
               2'd2: begin mul_a = 34'(radial_ff[0]); mul_b = 34'(pro_ff[1]); end
               default: ;
            endcase
         end
         ST_CRSB: begin
            case (ci)
               2'd0: begin mul_a = 34'(radial_ff[2]); mul_b = 34'(pro_ff[1]); end
               2'd1: begin mul_a = 34'(radial_ff[0]); mul_b = 34'(pro_ff[2]); end
               2'd2: begin mul_a = 34'(radial_ff[1]); mul_b = 34'(pro_ff[0]); end
               default: ;
            endcase
         end
         ST_THR: begin
            if (cnt_ff < 3'd3) begin
               mul_a = 34'(dir[ci]);
               mul_b = $signed({2'd0, power_ff[39:8]});
            end
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      st_in = st_ff;
      item_in = item_ff;
      act_in = act_ff;
      rst_in = rst_ff;
      cnt_in = cnt_ff;
      it_in = it_ff;
      nsel_in = nsel_ff;
      proda_in = proda_ff;
      power_in = power_ff;
      md_in = md_ff;
      num_in = num_ff;
      vec_in = vec_ff;
      sum_in = sum_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      drem_in = drem_ff;
      q_in = q_ff;
      radial_in = radial_ff;
      pro_in = pro_ff;
      normal_in = normal_ff;
      thrust_in = thrust_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      mass_in = mass_ff;
      rthr_in = rthr_ff;
      rburn_in = rburn_ff;
      rmass_in = rmass_ff;
      rfuel_in = rfuel_ff;
      item_pop = 1'b0;
      thr_clear = 1'b0;

      rem2 = {rem_ff, sum_ff[63:62]};
      sq_ge = rem2 >= {2'd0, root_ff, 2'b01};
      nd_ge = drem_ff >= {2'd0, root_ff};
      nd_sub = nd_ge ? drem_ff - {2'd0, root_ff} : drem_ff;
      qn = {q_ff[F-1:0], nd_ge};
      uq = $signed({1'b0, qn});
      unit = (root_ff == 32'd0) ? '0 : (vec_ff[ci][32] ? -uq : uq);
      cdiff = proda_ff - $signed(prod_ff[63:0]);
      cadj = cdiff + (cdiff[63] ? $signed(RND64) : 64'sd0);
      ctr = cadj >>> F;
      tadj = prod_ff + (prod_ff[67] ? $signed(RND68) : 68'sd0);
      ttr = tadj >>> F;
      dv_r = {dr_ff[35:0], dq_ff[63]};
      dv_ge = dv_r >= {1'b0, md_ff};
      fuel = mass_ff - cfg.dry_mass;
      burn = act_ff ? ((dq_ff > {24'd0, fuel}) ? fuel : dq_ff[39:0]) : 40'd0;
      restore_mass = (cfg.start_mass > cfg.dry_mass) ? cfg.start_mass : cfg.dry_mass;
      mass_new = rst_ff ? restore_mass : mass_ff - burn;
      load = (st_ff == ST_FIN) && (!rvalid_ff || rsp_chan.ready);
      case (cnt_ff)
         3'd1: part = {39'd0, prod_ff[40:0]};
         3'd2: part = {39'd0, prod_ff[40:0]} << 20;
         3'd3: part = {39'd0, prod_ff[40:0]} << 21;
         default: part = {39'd0, prod_ff[40:0]} << 41;
      endcase

      case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in = item;
               rst_in = (item.kind == otv_pkg::KIND_RESTORE);
               act_in = (item.kind == otv_pkg::KIND_STEP) && (cfg.throttle != 17'd0)
                        && (mass_ff > cfg.dry_mass);
               st_in = ((item.kind == otv_pkg::KIND_STEP) && (cfg.throttle != 17'd0)
                        && (mass_ff > cfg.dry_mass)) ? ST_PWR : ST_FIN;
            end
         end
         ST_PWR: st_in = ST_ISP;
         ST_ISP: begin
            power_in = prod_ff[39:0];
            num_in = 80'd0;
            cnt_in = 3'd0;
            st_in = ST_NUM;
         end
         ST_NUM: begin
            if (cnt_ff == 3'd0) begin
               md_in = prod_ff[35:0];
            end else begin
               num_in = num_ff + part;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               vec_in[0] = 33'(item_ff.pos_x);
               vec_in[1] = 33'(item_ff.pos_y);
               vec_in[2] = 33'(item_ff.pos_z);
               nsel_in = 2'd0;
               cnt_in = 3'd0;
               sum_in = 64'd0;
               st_in = ST_NSQ;
            end
         end
         ST_NSQ: begin
            if (cnt_ff != 3'd0) begin
               sum_in = sum_ff + prod_ff[63:0];
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               it_in = 6'd0;
               rem_in = 34'd0;
               root_in = 32'd0;
               st_in = ST_NSQRT;
            end
         end
         ST_NSQRT: begin
            rem_in = 34'(sq_ge ? rem2 - {2'd0, root_ff, 2'b01} : rem2);
            root_in = {root_ff[30:0], sq_ge};
            sum_in = sum_ff << 2;
            it_in = it_ff + 6'd1;
            if (it_ff == SQRT_LAST) begin
               cnt_in = 3'd0;
               st_in = ST_NDLD;
            end
         end
         ST_NDLD: begin
            drem_in = {2'd0, mag[ci]};
            q_in = '0;
            it_in = 6'd0;
            st_in = ST_NDIV;
         end
         ST_NDIV: begin
            q_in = qn;
            drem_in = nd_sub << 1;
            it_in = it_ff + 6'd1;
            if (it_ff == NDIV_LAST) begin
               case (nsel_ff)
                  2'd0:    radial_in[ci] = unit;
                  2'd1:    pro_in[ci] = unit;
                  default: normal_in[ci] = unit;
               endcase
               cnt_in = cnt_ff + 3'd1;
               st_in = ST_NDLD;
               if (cnt_ff == 3'd2) begin
                  cnt_in = 3'd0;
                  case (nsel_ff)
                     2'd0: begin
                        vec_in[0] = 33'(item_ff.vel_x);
                        vec_in[1] = 33'(item_ff.vel_y);
                        vec_in[2] = 33'(item_ff.vel_z);
                        nsel_in = 2'd1;
                        sum_in = 64'd0;
                        st_in = ST_NSQ;
                     end
                     2'd1:    st_in = ST_CRSA;
                     default: st_in = ST_THR;
                  endcase
               end
            end
         end
         ST_CRSA: st_in = ST_CRSB;
         ST_CRSB: begin
            proda_in = $signed(prod_ff[63:0]);
            st_in = ST_CRSD;
         end
         ST_CRSD: begin
            vec_in[ci] = ctr[32:0];
            cnt_in = cnt_ff + 3'd1;
            st_in = ST_CRSA;
            if (cnt_ff == 3'd2) begin
               cnt_in = 3'd0;
               if (vec_ff[0] == 33'sd0 && vec_ff[1] == 33'sd0 && ctr[32:0] == 33'd0) begin
                  normal_in[0] = '0;
                  normal_in[1] = '0;
                  normal_in[2] = ONE_DIR;
                  st_in = ST_THR;
               end else begin
                  nsel_in = 2'd2;
                  sum_in = 64'd0;
                  st_in = ST_NSQ;
               end
            end
         end
         ST_THR: begin
            if (cnt_ff != 3'd0) begin
               thrust_in[ti] = ttr[32:0];
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               dq_in = num_ff[79:16];
               dr_in = 37'd0;
               it_in = 6'd0;
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dr_in = dv_ge ? dv_r - {1'b0, md_ff} : dv_r;
            dq_in = {dq_ff[62:0], dv_ge};
            it_in = it_ff + 6'd1;
            if (it_ff == DIV_LAST) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load) begin
               for (int i = 0; i < 3; i++) begin
                  rthr_in[i] = act_ff ? thrust_ff[i] : 33'sd0;
               end
               rburn_in = burn;
               rmass_in = mass_new;
               rfuel_in = (mass_new <= cfg.dry_mass);
               mass_in = mass_new;
               thr_clear = rst_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      rvalid_in = load || (rvalid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rvalid_ff <= 1'b0;
         mass_ff <= 40'd0;
      end else begin
         st_ff <= st_in;
         rvalid_ff <= rvalid_in;
         mass_ff <= mass_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      act_ff <= act_in;
      rst_ff <= rst_in;
      cnt_ff <= cnt_in;
      it_ff <= it_in;
      nsel_ff <= nsel_in;
      prod_ff <= prod_in;
      proda_ff <= proda_in;
      power_ff <= power_in;
      md_ff <= md_in;
      num_ff <= num_in;
      vec_ff <= vec_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      q_ff <= q_in;
      radial_ff <= radial_in;
      pro_ff <= pro_in;
      normal_ff <= normal_in;
      thrust_ff <= thrust_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      rthr_ff <= rthr_in;
      rburn_ff <= rburn_in;
      rmass_ff <= rmass_in;
      rfuel_ff <= rfuel_in;
   end

   assign rsp_chan.valid = rvalid_ff;
   assign rsp_chan.thrust_x = rthr_ff[0];
   assign rsp_chan.thrust_y = rthr_ff[1];
   assign rsp_chan.thrust_z = rthr_ff[2];
   assign rsp_chan.burned = rburn_ff;
   assign rsp_chan.mass_now = rmass_ff;
   assign rsp_chan.out_of_fuel = rfuel_ff;

endmodule
